### sv/window_extreme_bars_since_assert.svh
// assertion macros shared by the bars-since controller and datapath
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef WINDOW_EXTREME_BARS_SINCE_ASSERT_SVH
`define WINDOW_EXTREME_BARS_SINCE_ASSERT_SVH
`ifndef SYNTHESIS
`define WEBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define WEBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WEBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define WEBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/webs_pkg.sv
// types and constants for the windowed extreme bars-since block
// used by every module of the block but webs_ram; no dependencies
package webs_pkg;

    localparam int HISTORY_DEPTH = 1024;
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

    localparam int SAMPLE_W   = 32;
    localparam int BARS_W     = 10;
    localparam int ABS_TOL_W  = 31;
    localparam int REL_TOL_W  = 32;
    localparam int TOL_W      = 33;
    localparam int CMP_W      = 35;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(HISTORY_DEPTH - 1);

    localparam logic signed [SAMPLE_W-1:0] MISSING_SAMPLE = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_FIND_LOWEST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ABS_TOL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_TOL     = 2'd2;

    typedef struct packed {
        logic                       new_series;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sample_missing;
        logic signed [31:0]         window_length;
        logic                       window_missing;
    } t_in;

    typedef struct packed {
        logic [BARS_W-1:0] bars_since;
        logic              result_missing;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic skip;
        logic issue_last;
        logic scan_done;
    } t_status;

endpackage

### sv/window_extreme_bars_since.sv
// bars since the highest or lowest bar in a sliding window of a history ring.
// input channel: i_in_valid / o_in_stall with payload i_in_payload (new_series,
// sample, sample_missing, window_length, window_missing). output channel:
// o_out_valid / i_out_stall with payload o_out_payload (bars_since, result_missing).
// a transaction moves at a rising edge where valid is high and stall is low.
// configuration is a plain write port: i_cfg_we, i_cfg_index, i_cfg_data; the
// user must write it only while the block is idle; the block does not enforce this.
// each bar is written to a 1024 entry history ram, then the window is scanned
// oldest to newest through a three stage read / multiply / compare pipeline,
// one bar per cycle, set by the single ram read port.
// an item goes through the decide, scan, drain and finish states before its
// result turns valid; an item with a missing result goes from decide straight
// to finish. the block leaves finish and drops o_in_stall in the same cycle
// as the result turns valid.
// the next item is accepted once the result is in the output register, even
// while the receiver stalls it; a stalled result holds until taken, and a
// second finished result waits inside the block.
// synchronous active low reset clears the history pointer, count, started
// flag, configuration and valid flags; ram contents are not cleared.
// depends on webs_pkg, webs_ctrl, webs_dp and webs_ram
module window_extreme_bars_since (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  webs_pkg::t_in                   i_in_payload,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output webs_pkg::t_out                  o_out_payload,
    input  logic                            i_cfg_we,
    input  logic [webs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [webs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    webs_pkg::t_cmd    cmd;
    webs_pkg::t_status status;

    webs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    webs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in_payload),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out      (o_out_payload)
    );

endmodule

### sv/webs_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module webs_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/webs_ctrl.sv
// sequencing state machine for the bars-since block
// depends on webs_pkg and window_extreme_bars_since_assert.svh
`include "window_extreme_bars_since_assert.svh"

module webs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output webs_pkg::t_cmd    o_cmd,
    input  webs_pkg::t_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd.load     = i_in_valid && (r_state == S_IDLE);
        o_cmd.issue    = (r_state == S_SCAN);
        o_cmd.out_load = (r_state == S_FINISH) && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = i_status.skip ? S_FINISH : S_SCAN;
            end
            S_SCAN: begin
                if (i_status.issue_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (i_status.scan_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // the last candidate only reaches the compare stage after issuing stops
    `WEBS_ASSERT_IMP(a_done_in_drain, i_clk, i_rst_n, i_status.scan_done, r_state == S_DRAIN, "scan finished outside drain")
    `WEBS_ASSERT_NXT(a_finish_shows, i_clk, i_rst_n, (r_state == S_FINISH) && !r_out_valid, r_out_valid, "finished result not presented")
    `WEBS_ASSERT_NXT(a_out_held, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid, "stalled result dropped")

endmodule

### sv/webs_dp.sv
// datapath: history ram, window setup, pipelined tolerance scan, result register
// depends on webs_pkg, webs_ram and window_extreme_bars_since_assert.svh
`include "window_extreme_bars_since_assert.svh"

module webs_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [webs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [webs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  webs_pkg::t_in                       i_in,
    input  webs_pkg::t_cmd                      i_cmd,
    output webs_pkg::t_status                   o_status,
    output webs_pkg::t_out                      o_out
);

    localparam int AW = webs_pkg::ADDR_W;
    localparam int CW = webs_pkg::CNT_W;
    localparam int SW = webs_pkg::SAMPLE_W;

    // configuration
    logic                             r_find_lowest;
    logic [webs_pkg::ABS_TOL_W-1:0]   r_abs_tol;
    logic [webs_pkg::REL_TOL_W-1:0]   r_rel_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_find_lowest <= 1'b0;
            r_abs_tol     <= '0;
            r_rel_tol     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                webs_pkg::CFG_FIND_LOWEST: r_find_lowest <= i_cfg_data[0];
                webs_pkg::CFG_ABS_TOL:     r_abs_tol <= i_cfg_data[webs_pkg::ABS_TOL_W-1:0];
                webs_pkg::CFG_REL_TOL:     r_rel_tol <= i_cfg_data[webs_pkg::REL_TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // history write and window setup on a new transaction
    logic [AW-1:0] r_wr_ptr;
    logic [CW-1:0] r_count;
    logic          r_started;
    logic [AW-1:0] r_newest;
    logic          r_skip;
    logic [AW-1:0] r_age;
    logic          r_first_pend;

    logic [AW-1:0] wsel;
    logic [CW-1:0] cnt_base;
    logic [CW-1:0] cnt_next;
    logic          started_next;
    logic          use_all;
    logic [CW-1:0] window;
    logic [SW-1:0] wdata;

    always_comb begin
        wsel         = i_in.new_series ? '0 : r_wr_ptr;
        cnt_base     = i_in.new_series ? '0 : r_count;
        cnt_next     = (cnt_base == webs_pkg::DEPTH_CNT) ? cnt_base : cnt_base + 1'b1;
        started_next = (r_started && !i_in.new_series) || !i_in.sample_missing;
        use_all      = i_in.window_length[31] || (i_in.window_length == '0) ||
                       ($unsigned(i_in.window_length) > 32'(cnt_next));
        window       = use_all ? cnt_next : i_in.window_length[CW-1:0];
        wdata        = i_in.sample_missing ? webs_pkg::MISSING_SAMPLE : i_in.sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_count   <= '0;
            r_started <= 1'b0;
        end else if (i_cmd.load) begin
            r_wr_ptr  <= (wsel == webs_pkg::LAST_ADDR) ? '0 : wsel + 1'b1;
            r_count   <= cnt_next;
            r_started <= started_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_newest     <= wsel;
            r_skip       <= !started_next || i_in.window_missing;
            r_age        <= AW'(window - 1'b1);
            r_first_pend <= 1'b1;
        end else if (i_cmd.issue) begin
            r_age        <= r_age - 1'b1;
            r_first_pend <= 1'b0;
        end
    end

    // read address of the bar at r_age, wrapping around the ring
    logic [AW-1:0] raddr;
    logic [SW-1:0] rdata;

    assign raddr = (r_age <= r_newest) ? r_newest - r_age :
                   AW'(CW'(r_newest) + webs_pkg::DEPTH_CNT - CW'(r_age));

    webs_ram #(
        .DATA_W(SW),
        .DEPTH (webs_pkg::HISTORY_DEPTH)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load),
        .i_waddr(wsel),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // read stage: ram data arrives, tolerance product is formed
    logic          r_rd_valid;
    logic [AW-1:0] r_rd_age;
    logic          r_rd_first;
    logic [SW-1:0] mag;
    logic [63:0]   prod;

    assign mag  = rdata[SW-1] ? (~rdata + 1'b1) : rdata;
    assign prod = 64'(mag) * 64'(r_rel_tol);

    // compare stage
    logic                      r_c_valid;
    logic [AW-1:0]             r_c_age;
    logic                      r_c_first;
    logic signed [SW-1:0]      r_c_val;
    logic [31:0]               r_c_prod_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_c_valid  <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.issue;
            r_c_valid  <= r_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_age    <= r_age;
        r_rd_first  <= r_first_pend;
        r_c_age     <= r_rd_age;
        r_c_first   <= r_rd_first;
        r_c_val     <= $signed(rdata);
        r_c_prod_hi <= prod[63:32];
    end

    logic [webs_pkg::TOL_W-1:0]        tol;
    logic signed [webs_pkg::CMP_W-1:0] c_x;
    logic signed [webs_pkg::CMP_W-1:0] tol_x;
    logic signed [webs_pkg::CMP_W-1:0] sel_x;
    logic signed [webs_pkg::CMP_W-1:0] c_plus;
    logic signed [webs_pkg::CMP_W-1:0] c_minus;
    logic signed [SW-1:0]              r_sel_val;
    logic [AW-1:0]                     r_sel_age;
    logic                              replace;

    always_comb begin
        tol     = webs_pkg::TOL_W'(r_c_prod_hi) + webs_pkg::TOL_W'(r_abs_tol);
        c_x     = {{(webs_pkg::CMP_W-SW){r_c_val[SW-1]}}, r_c_val};
        sel_x   = {{(webs_pkg::CMP_W-SW){r_sel_val[SW-1]}}, r_sel_val};
        tol_x   = {{(webs_pkg::CMP_W-webs_pkg::TOL_W){1'b0}}, tol};
        c_plus  = c_x + tol_x;
        c_minus = c_x - tol_x;
        // the oldest bar always seeds the running extreme
        replace = r_c_first || (r_find_lowest ? (sel_x > c_minus) : (sel_x < c_plus));
    end

    always_ff @(posedge i_clk) begin
        if (r_c_valid && replace) begin
            r_sel_val <= r_c_val;
            r_sel_age <= r_c_age;
        end
    end

    // result register
    webs_pkg::t_out r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.result_missing <= r_skip;
            r_out.bars_since     <= r_skip ? '0 : webs_pkg::BARS_W'(r_sel_age);
        end
    end

    assign o_out = r_out;

    always_comb begin
        o_status.skip       = r_skip;
        o_status.issue_last = (r_age == '0);
        o_status.scan_done  = r_c_valid && (r_c_age == '0);
    end

    `WEBS_ASSERT_IMP(a_load_pipe_empty, i_clk, i_rst_n, i_cmd.load, !r_rd_valid && !r_c_valid, "new transaction while scan in flight")
    `WEBS_ASSERT_IMP(a_last_is_last, i_clk, i_rst_n, r_c_valid && (r_c_age == '0), !r_rd_valid, "candidate behind the current bar")
    `WEBS_ASSERT_NXT(a_pipe_advance, i_clk, i_rst_n, r_rd_valid, r_c_valid, "read stage did not reach compare")

endmodule
